[rtl/skc_pkg.sv]
// Shared types and constants for the string key linear probe counter.
// Used by skc_ctrl, skc_datapath and the core top level; depends on nothing.
package skc_pkg;

    localparam int TABLE_SLOTS_DEF = 128;
    localparam int KEY_BYTES_DEF   = 40;
    localparam int STATUS_W        = 3;
    localparam int COUNT_W         = 16;
    localparam int TOTAL_W         = 24;
    localparam int SLOT_OUT_W      = 7;
    localparam int WORD_W          = 64;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW      = 3'd0,
        ST_EXISTING = 3'd1,
        ST_FOUND    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_BADKEY   = 3'd5
    } skc_status_t;

    // controller to datapath
    typedef struct packed {
        logic        absorb;
        logic        clr_init;
        logic        clr_step;
        logic        mod_init;
        logic        mod_step;
        logic        home_load;
        logic        meta_rd;
        logic        capture_meta;
        logic        step;
        logic        widx_clr;
        logic        widx_inc;
        logic        word_rd;
        logic        write_word;
        logic        write_meta_new;
        logic        write_meta_inc;
        logic        finish;
        skc_status_t code;
    } skc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_insert;
        logic key_bad;
        logic mod_last;
        logic slot_last;
        logic probe_last;
        logic meta_empty;
        logic meta_len_eq;
        logic word_eq;
        logic cmp_last;
        logic write_last;
    } skc_stat_t;

endpackage

[rtl/skc_ram.sv]
// Generic simple dual-port RAM with registered read.
// Depends on nothing.
module skc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/skc_datapath.sv]
// Datapath: key assembly, home slot remainder, probe pointers, slot RAMs, totals.
// Depends on skc_pkg and skc_ram.
module skc_datapath #(
    parameter int TABLE_SLOTS = skc_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = skc_pkg::KEY_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  skc_pkg::skc_cmd_t               cmd,
    output skc_pkg::skc_stat_t              stat,
    input  logic                            opcode,
    input  logic [7:0]                      key_byte,
    input  logic                            key_last,
    output logic                            done,
    output logic [skc_pkg::STATUS_W-1:0]    status,
    output logic [skc_pkg::COUNT_W-1:0]     occurrences,
    output logic [skc_pkg::SLOT_OUT_W-1:0]  slot_index,
    output logic [skc_pkg::TOTAL_W-1:0]     terms_total,
    output logic [skc_pkg::TOTAL_W-1:0]     collisions_total
);

    localparam int KW      = (KEY_BYTES + 7) / 8;
    localparam int WIDX_W  = (KW > 1) ? $clog2(KW) : 1;
    localparam int LEN_W   = $clog2(KEY_BYTES + 1);
    localparam int SUM_W   = $clog2(KEY_BYTES * 255 + 1);
    localparam int SCNT_W  = 1;
    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int ADDR_W  = $clog2(TABLE_SLOTS * KW);
    localparam int META_W  = LEN_W + skc_pkg::COUNT_W;
    localparam int CW      = skc_pkg::COUNT_W;
    localparam int TW      = skc_pkg::TOTAL_W;
    localparam int WW      = skc_pkg::WORD_W;
    // reciprocal of the slot count, scaled so the quotient estimate is at most one low
    localparam int     RK     = SUM_W + SLOT_W;
    localparam int     PROD_W = SUM_W + RK;
    localparam longint RECIP  = (64'd1 << RK) / TABLE_SLOTS;

    logic [WW-1:0]     key_word_reg [KW];
    logic [LEN_W-1:0]  key_len_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              ended_reg;
    logic              overlong_reg;
    logic              op_reg;
    logic [SUM_W-1:0]  quot_reg;
    logic [SLOT_W:0]   rem_reg;
    logic [SCNT_W-1:0] mod_cnt_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [SLOT_W-1:0] probe_reg;
    logic [WIDX_W-1:0] widx_reg;
    logic [CW-1:0]     count_reg;
    logic              done_reg;
    logic [skc_pkg::STATUS_W-1:0]   status_reg;
    logic [CW-1:0]                  occ_reg;
    logic [skc_pkg::SLOT_OUT_W-1:0] slot_out_reg;
    logic [TW-1:0]     terms_reg;
    logic [TW-1:0]     coll_reg;

    logic [WIDX_W-1:0] wr_widx;
    logic [2:0]        wr_pos;
    logic [PROD_W-1:0] recip_prod;
    logic [SUM_W-1:0]  rem_est;
    logic [CW-1:0]     count_inc;
    logic [TW:0]       coll_sum;
    logic [WIDX_W-1:0] last_widx;
    logic [ADDR_W-1:0] word_addr;
    logic              meta_we;
    logic [META_W-1:0] meta_wdata;
    logic [META_W-1:0] meta_rdata;
    logic [WW-1:0]     word_rdata;

    assign wr_widx    = WIDX_W'(key_len_reg >> 3);
    assign wr_pos     = 3'(key_len_reg);
    assign recip_prod = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign rem_est    = sum_reg - SUM_W'(quot_reg * TABLE_SLOTS);
    assign count_inc  = (count_reg == '1) ? count_reg : count_reg + CW'(1);
    assign coll_sum   = {1'b0, coll_reg} + (TW+1)'(probe_reg);
    assign last_widx  = WIDX_W'((key_len_reg - LEN_W'(1)) >> 3);
    assign word_addr  = base_reg + ADDR_W'(widx_reg);

    always_comb
    begin
        meta_we    = cmd.clr_step || cmd.write_meta_new || cmd.write_meta_inc;
        meta_wdata = '0;
        if (cmd.write_meta_new)
        begin
            meta_wdata = {key_len_reg, CW'(1)};
        end
        else if (cmd.write_meta_inc)
        begin
            meta_wdata = {key_len_reg, count_inc};
        end
    end

    skc_ram #(.WIDTH(META_W), .DEPTH(TABLE_SLOTS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (slot_reg),
        .wdata (meta_wdata),
        .re    (cmd.meta_rd),
        .raddr (slot_reg),
        .rdata (meta_rdata)
    );

    skc_ram #(.WIDTH(WW), .DEPTH(TABLE_SLOTS * KW)) u_word_ram (
        .clk   (clk),
        .we    (cmd.write_word),
        .waddr (word_addr),
        .wdata (key_word_reg[widx_reg]),
        .re    (cmd.word_rd),
        .raddr (word_addr),
        .rdata (word_rdata)
    );

    always_comb
    begin
        stat.is_insert   = !op_reg;
        stat.key_bad     = (key_len_reg == '0) || overlong_reg;
        stat.mod_last    = (mod_cnt_reg == SCNT_W'(1));
        stat.slot_last   = (slot_reg == SLOT_W'(TABLE_SLOTS - 1));
        stat.probe_last  = (probe_reg == SLOT_W'(TABLE_SLOTS - 1));
        stat.meta_empty  = (meta_rdata[META_W-1:CW] == '0);
        stat.meta_len_eq = (meta_rdata[META_W-1:CW] == key_len_reg);
        stat.word_eq     = (word_rdata == key_word_reg[widx_reg]);
        stat.cmp_last    = (widx_reg == last_widx);
        stat.write_last  = (widx_reg == WIDX_W'(KW - 1));
    end

    // key words and payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.absorb && !ended_reg && key_byte != 8'd0 && key_len_reg < LEN_W'(KEY_BYTES))
        begin
            for (int i = 0; i < KW; i++)
            begin
                if (wr_widx == WIDX_W'(i))
                begin
                    if (wr_pos == 3'd0)
                    begin
                        key_word_reg[i] <= WW'(key_byte);
                    end
                    else
                    begin
                        key_word_reg[i] <= key_word_reg[i] | (WW'(key_byte) << {wr_pos, 3'd0});
                    end
                end
            end
        end
        if (cmd.absorb && key_last)
        begin
            op_reg <= opcode;
        end
        // quotient estimate from the reciprocal, at most one below the true quotient
        if (cmd.mod_init)
        begin
            quot_reg <= recip_prod[PROD_W-1:RK];
        end
        if (cmd.capture_meta)
        begin
            count_reg <= meta_rdata[CW-1:0];
        end
        if (cmd.finish)
        begin
            status_reg   <= cmd.code;
            occ_reg      <= '0;
            slot_out_reg <= '0;
            case (cmd.code)
                skc_pkg::ST_NEW:
                begin
                    occ_reg      <= CW'(1);
                    slot_out_reg <= skc_pkg::SLOT_OUT_W'(slot_reg);
                end
                skc_pkg::ST_EXISTING:
                begin
                    occ_reg      <= count_inc;
                    slot_out_reg <= skc_pkg::SLOT_OUT_W'(slot_reg);
                end
                skc_pkg::ST_FOUND:
                begin
                    occ_reg      <= count_reg;
                    slot_out_reg <= skc_pkg::SLOT_OUT_W'(slot_reg);
                end
                default:
                begin
                    occ_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg  <= '0;
            sum_reg      <= '0;
            ended_reg    <= 1'b0;
            overlong_reg <= 1'b0;
            rem_reg      <= '0;
            mod_cnt_reg  <= '0;
            slot_reg     <= '0;
            base_reg     <= '0;
            probe_reg    <= '0;
            widx_reg     <= '0;
            done_reg     <= 1'b0;
            terms_reg    <= '0;
            coll_reg     <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.absorb && !ended_reg)
            begin
                if (key_byte == 8'd0)
                begin
                    ended_reg <= 1'b1;
                end
                else if (key_len_reg >= LEN_W'(KEY_BYTES))
                begin
                    overlong_reg <= 1'b1;
                end
                else
                begin
                    key_len_reg <= key_len_reg + LEN_W'(1);
                    sum_reg     <= sum_reg + SUM_W'(key_byte);
                end
            end
            // first step: subtract quotient times slots; second step: one correction
            if (cmd.mod_init)
            begin
                mod_cnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + SCNT_W'(1);
                if (mod_cnt_reg == '0)
                begin
                    rem_reg <= (SLOT_W+1)'(rem_est);
                end
                else if (rem_reg >= (SLOT_W+1)'(TABLE_SLOTS))
                begin
                    rem_reg <= rem_reg - (SLOT_W+1)'(TABLE_SLOTS);
                end
            end
            if (cmd.clr_init)
            begin
                slot_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            else if (cmd.home_load)
            begin
                slot_reg  <= SLOT_W'(rem_reg);
                base_reg  <= ADDR_W'(rem_reg * KW);
                probe_reg <= '0;
            end
            else if (cmd.step)
            begin
                probe_reg <= probe_reg + SLOT_W'(1);
                if (stat.slot_last)
                begin
                    slot_reg <= '0;
                    base_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                    base_reg <= base_reg + ADDR_W'(KW);
                end
            end
            if (cmd.widx_clr)
            begin
                widx_reg <= '0;
            end
            else if (cmd.widx_inc)
            begin
                widx_reg <= widx_reg + WIDX_W'(1);
            end
            if (cmd.finish)
            begin
                key_len_reg  <= '0;
                sum_reg      <= '0;
                ended_reg    <= 1'b0;
                overlong_reg <= 1'b0;
                if (cmd.code == skc_pkg::ST_NEW || cmd.code == skc_pkg::ST_EXISTING)
                begin
                    if (terms_reg != '1)
                    begin
                        terms_reg <= terms_reg + TW'(1);
                    end
                    coll_reg <= (coll_sum >= (TW+1)'({TW{1'b1}})) ? '1 : coll_sum[TW-1:0];
                end
            end
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign occurrences      = occ_reg;
    assign slot_index       = slot_out_reg;
    assign terms_total      = terms_reg;
    assign collisions_total = coll_reg;

endmodule

[rtl/skc_ctrl.sv]
// Controller state machine: clearing pass, key check, remainder, probe walk.
// Depends on skc_pkg.
module skc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               key_last,
    output logic               busy,
    input  skc_pkg::skc_stat_t stat,
    output skc_pkg::skc_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_MOD, S_HOME, S_READ_META,
        S_EVAL_META, S_WRITE, S_CMP_RD, S_CMP_EV
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.code   = skc_pkg::ST_BADKEY;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.slot_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.absorb = 1'b1;
                    if (key_last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.key_bad)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.mod_init = 1'b1;
                    state_next   = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                cmd.home_load = 1'b1;
                state_next    = S_READ_META;
            end
            S_READ_META:
            begin
                cmd.meta_rd = 1'b1;
                state_next  = S_EVAL_META;
            end
            S_EVAL_META:
            begin
                cmd.capture_meta = 1'b1;
                cmd.widx_clr     = 1'b1;
                if (stat.meta_empty)
                begin
                    if (stat.is_insert)
                    begin
                        cmd.write_meta_new = 1'b1;
                        state_next         = S_WRITE;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = skc_pkg::ST_NOTFOUND;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.meta_len_eq)
                begin
                    state_next = S_CMP_RD;
                end
                else if (stat.probe_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = stat.is_insert ? skc_pkg::ST_FULL : skc_pkg::ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ_META;
                end
            end
            S_WRITE:
            begin
                cmd.write_word = 1'b1;
                if (stat.write_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = skc_pkg::ST_NEW;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.widx_inc = 1'b1;
                end
            end
            S_CMP_RD:
            begin
                cmd.word_rd = 1'b1;
                state_next  = S_CMP_EV;
            end
            S_CMP_EV:
            begin
                if (!stat.word_eq)
                begin
                    if (stat.probe_last)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = stat.is_insert ? skc_pkg::ST_FULL : skc_pkg::ST_NOTFOUND;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = S_READ_META;
                    end
                end
                else if (stat.cmp_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                    if (stat.is_insert)
                    begin
                        cmd.write_meta_inc = 1'b1;
                        cmd.code           = skc_pkg::ST_EXISTING;
                    end
                    else
                    begin
                        cmd.code = skc_pkg::ST_FOUND;
                    end
                end
                else
                begin
                    cmd.widx_inc = 1'b1;
                    state_next   = S_CMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a request is absorbed only while idle
    a_absorb_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.absorb |-> (state_reg == S_IDLE))
        else $error("key byte absorbed while busy");

    // word RAM is never read and written in the same cycle
    a_word_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.word_rd && cmd.write_word))
        else $error("word RAM read and write collide");

    // a finished request always returns to idle
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE))
        else $error("finish did not return to idle");

endmodule

[rtl/string_key_linear_probe_counter_core.sv]
// Top level of the string key linear probe counter.
// Depends on skc_pkg, skc_ctrl, skc_datapath, skc_ram.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+--------------------------
//  request   | opcode, key_byte, key_last                    | start && !busy
//  result    | status, occurrences, slot_index, terms_total, | done, one cycle, no stall
//            | collisions_total                              |
//
// Sequence: a byte without key_last is absorbed in S_IDLE. A last byte with an empty or
//   overlong key is rejected in S_CHECK. Any other last byte passes key check, a
//   two-step reciprocal remainder and home load, then one meta RAM read per slot
//   probed, a read and compare per key word compared, and a write of every key word
//   on a new insert. done is registered from the finishing command, in the cycle after.
// Reset: after rst_n releases, a clearing pass writes every slot empty, with busy high.
// Stalls: the receiver cannot stall; each result shows for one cycle with done.
module string_key_linear_probe_counter_core #(
    parameter int TABLE_SLOTS = skc_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = skc_pkg::KEY_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            opcode,
    input  logic [7:0]                      key_byte,
    input  logic                            key_last,
    output logic                            done,
    output logic [skc_pkg::STATUS_W-1:0]    status,
    output logic [skc_pkg::COUNT_W-1:0]     occurrences,
    output logic [skc_pkg::SLOT_OUT_W-1:0]  slot_index,
    output logic [skc_pkg::TOTAL_W-1:0]     terms_total,
    output logic [skc_pkg::TOTAL_W-1:0]     collisions_total
);

    skc_pkg::skc_cmd_t  cmd;
    skc_pkg::skc_stat_t stat;

    // sequencer: owns busy and every datapath command
    skc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .key_last (key_last),
        .busy     (busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    // key assembly, slot RAMs and result registers
    skc_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .opcode           (opcode),
        .key_byte         (key_byte),
        .key_last         (key_last),
        .done             (done),
        .status           (status),
        .occurrences      (occurrences),
        .slot_index       (slot_index),
        .terms_total      (terms_total),
        .collisions_total (collisions_total)
    );

endmodule

[dv/string_key_linear_probe_counter_core_test.sv]
// Self-checking testbench for string_key_linear_probe_counter_core.
// Depends on rtl/skc_pkg.sv and the core RTL; streams key bytes, predicts each
// probe result in a local table model and checks every done strobe against it.
module string_key_linear_probe_counter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 128;
    localparam int KEY_MAX    = 40;
    localparam int TAIL_WAIT  = 600;
    localparam int CYCLE_CAP  = 20000000;
    localparam bit OP_INSERT  = 1'b0;
    localparam bit OP_LOOKUP  = 1'b1;

    // one request as it goes on the ports, plus a drain mark for the driver
    typedef struct {
        bit       op;
        bit [7:0] kbyte;
        bit       last;
        bit       drain;
    } key_req_t;

    typedef struct {
        skc_pkg::skc_status_t st;
        bit [15:0]    occ;
        bit [6:0]     slot;
        bit [23:0]    terms;
        bit [23:0]    probes;
    } probe_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        opcode = 1'b0;
    logic [7:0]  key_byte = 8'd0;
    logic        key_last = 1'b0;
    logic        busy, done;
    logic [2:0]  status;
    logic [15:0] occurrences;
    logic [6:0]  slot_index;
    logic [23:0] terms_total, collisions_total;

    string_key_linear_probe_counter_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .key_byte(key_byte), .key_last(key_last),
        .done(done), .status(status), .occurrences(occurrences),
        .slot_index(slot_index), .terms_total(terms_total),
        .collisions_total(collisions_total)
    );

    always #5 clk = ~clk;

    key_req_t   pending_reqs[$];
    probe_res_t awaited_results[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         idle_pct = 0;
    bit         stim_done = 1'b0;
    bit         took_req = 1'b0;

    // shadow of the hash table and of the key being assembled
    bit [7:0]  asm_bytes[KEY_MAX];
    int        asm_len = 0;
    int        asm_sum = 0;
    bit        asm_ended = 1'b0;
    bit        asm_overlong = 1'b0;
    bit [7:0]  tbl_bytes[SLOTS][KEY_MAX];
    int        tbl_len[SLOTS];
    int        tbl_cnt[SLOTS];
    int        word_total = 0;
    int        step_total = 0;

    function automatic int sat_sum(int a, int b, int cap);
        return (a + b > cap) ? cap : a + b;
    endfunction

    function automatic bit slot_holds_key(int s);
        if (tbl_len[s] != asm_len)
            return 1'b0;
        for (int i = 0; i < asm_len; i++)
            if (tbl_bytes[s][i] != asm_bytes[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the shadow by one request; return 1 with the result on key_last.
    function automatic bit count_key_byte(key_req_t r, output probe_res_t res);
        int home, s, i;
        res.st = skc_pkg::ST_BADKEY;
        res.occ = 0;
        res.slot = 0;
        if (!asm_ended) begin
            if (r.kbyte == 8'd0)
                asm_ended = 1'b1;
            else if (asm_len >= KEY_MAX)
                asm_overlong = 1'b1;
            else begin
                asm_bytes[asm_len] = r.kbyte;
                asm_len++;
                asm_sum += r.kbyte;
            end
        end
        if (!r.last)
            return 1'b0;
        if (asm_len != 0 && !asm_overlong) begin
            home = asm_sum % SLOTS;
            res.st = (r.op == OP_INSERT) ? skc_pkg::ST_FULL : skc_pkg::ST_NOTFOUND;
            for (i = 0; i < SLOTS; i++) begin
                s = (home + i) % SLOTS;
                if (tbl_len[s] == 0) begin
                    if (r.op == OP_INSERT) begin
                        for (int j = 0; j < KEY_MAX; j++)
                            tbl_bytes[s][j] = (j < asm_len) ? asm_bytes[j] : 8'd0;
                        tbl_len[s] = asm_len;
                        tbl_cnt[s] = 1;
                        res.st = skc_pkg::ST_NEW;
                        res.occ = 1;
                        res.slot = 7'(s);
                    end
                    break;
                end
                if (slot_holds_key(s)) begin
                    if (r.op == OP_INSERT) begin
                        tbl_cnt[s] = sat_sum(tbl_cnt[s], 1, 16'hFFFF);
                        res.st = skc_pkg::ST_EXISTING;
                    end else
                        res.st = skc_pkg::ST_FOUND;
                    res.occ = 16'(tbl_cnt[s]);
                    res.slot = 7'(s);
                    break;
                end
            end
            if (r.op == OP_INSERT &&
                (res.st == skc_pkg::ST_NEW || res.st == skc_pkg::ST_EXISTING)) begin
                word_total = sat_sum(word_total, 1, 24'hFFFFFF);
                step_total = sat_sum(step_total, i, 24'hFFFFFF);
            end
        end
        asm_len = 0;
        asm_sum = 0;
        asm_ended = 1'b0;
        asm_overlong = 1'b0;
        res.terms = 24'(word_total);
        res.probes = 24'(step_total);
        return 1'b1;
    endfunction

    // Monitor: check the strobed result first, then model any request taken now.
    always @(posedge clk)
    begin
        key_req_t   r;
        probe_res_t res, want;
        bit         took;
        cycle_count <= cycle_count + 1;
        took = 1'b0;
        if (done) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: status %0d", status);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (status !== want.st) begin
                    $error("status exp %0d got %0d", want.st, status); fail_count++;
                end
                if (occurrences !== want.occ) begin
                    $error("occurrences exp %0d got %0d", want.occ, occurrences);
                    fail_count++;
                end
                if (slot_index !== want.slot) begin
                    $error("slot_index exp %0d got %0d", want.slot, slot_index);
                    fail_count++;
                end
                if (terms_total !== want.terms) begin
                    $error("terms_total exp %0d got %0d", want.terms, terms_total);
                    fail_count++;
                end
                if (collisions_total !== want.probes) begin
                    $error("collisions_total exp %0d got %0d", want.probes,
                           collisions_total);
                    fail_count++;
                end
            end
        end
        if (rst_n && start && !busy) begin
            r.op = opcode;
            r.kbyte = key_byte;
            r.last = key_last;
            r.drain = 1'b0;
            if (count_key_byte(r, res))
                awaited_results.push_back(res);
            took = 1'b1;
        end
        took_req <= took;
    end

    // Driver: hold start until the request is taken, then advance or idle.
    always @(negedge clk)
    begin
        key_req_t r;
        bit       drive;
        drive = start && !took_req;
        if (!drive && rst_n && pending_reqs.size() != 0) begin
            r = pending_reqs[0];
            if (r.drain && awaited_results.size() != 0)
                drive = 1'b0;
            else if ($urandom_range(99) < idle_pct)
                drive = 1'b0;
            else begin
                void'(pending_reqs.pop_front());
                opcode <= r.op;
                key_byte <= r.kbyte;
                key_last <= r.last;
                drive = 1'b1;
            end
        end
        start <= drive;
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Queue one key as a byte stream; the opcode rides on every byte.
    task automatic queue_key(input bit [7:0] kb[$], input bit op, input bit drain = 1'b0);
        key_req_t r;
        for (int i = 0; i < kb.size(); i++) begin
            r.op = op;
            r.kbyte = kb[i];
            r.last = (i == kb.size() - 1);
            r.drain = drain && (i == 0);
            pending_reqs.push_back(r);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || start || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    bit [7:0] vocab[24][$];

    initial
    begin
        bit [7:0] kb[$];
        int       n, pick, phase;
        key_req_t r;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: bad keys, new/existing/found/not found, same-sum collisions
        kb = {8'h00};                       queue_key(kb, OP_INSERT);
        kb = {8'h00, 8'h41};                queue_key(kb, OP_LOOKUP);
        kb = {8'h61, 8'h62};                queue_key(kb, OP_LOOKUP);
        kb = {8'h61, 8'h62};                queue_key(kb, OP_INSERT);
        kb = {8'h61, 8'h62};                queue_key(kb, OP_INSERT);
        kb = {8'h62, 8'h61};                queue_key(kb, OP_INSERT);
        kb = {8'h62, 8'h61};                queue_key(kb, OP_LOOKUP);
        kb = {8'h61, 8'h62, 8'h00, 8'hFF};  queue_key(kb, OP_LOOKUP);
        kb = {8'hFF};                       queue_key(kb, OP_INSERT);
        kb = {8'h01, 8'h7F};                queue_key(kb, OP_INSERT);
        kb = {8'h80};                       queue_key(kb, OP_LOOKUP);
        kb.delete();
        for (int i = 0; i < KEY_MAX; i++) kb.push_back(8'h5A);
        queue_key(kb, OP_INSERT);
        kb.push_back(8'h5A);                queue_key(kb, OP_INSERT);
        kb[KEY_MAX] = 8'h00;                queue_key(kb, OP_LOOKUP);

        // vocabulary of short keys so that inserts and lookups hit often
        foreach (vocab[i]) begin
            n = $urandom_range(1, 6);
            for (int j = 0; j < n; j++)
                vocab[i].push_back(8'($urandom_range(8'h61, 8'h68)));
        end

        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            idle_pct = (phase == 1) ? 53 : (phase == 3) ? 24 : 0;
            n = 0;
            while (n < 260) begin
                pick = $urandom_range(99);
                kb.delete();
                if (pick < 78) begin
                    kb = vocab[$urandom_range(23)];
                    queue_key(kb, ($urandom_range(99) < 65) ? OP_INSERT : OP_LOOKUP,
                              pick == 0);
                end else if (pick < 88) begin
                    repeat ($urandom_range(1, KEY_MAX + 4))
                        kb.push_back(8'($urandom_range(1, 255)));
                    queue_key(kb, 1'($urandom_range(1)));
                end else if (pick < 94) begin
                    repeat ($urandom_range(0, 3)) kb.push_back(8'($urandom_range(1, 255)));
                    kb.push_back(8'h00);
                    repeat ($urandom_range(0, 3)) kb.push_back(8'($urandom_range(255)));
                    queue_key(kb, 1'($urandom_range(1)));
                end else begin
                    // noise: raw bytes with a random last flag
                    r.op = 1'($urandom_range(1));
                    r.kbyte = 8'($urandom_range(255));
                    r.last = 1'($urandom_range(1));
                    r.drain = 1'b0;
                    pending_reqs.push_back(r);
                    kb.push_back(r.kbyte);
                end
                n += kb.size();
            end
        end

        // fill the table until inserts report full, then probe it
        wait_drained();
        idle_pct = 0;
        for (int i = 1; i <= 140; i++) begin
            kb = {8'hFA, i[7:0], 8'hF5};
            queue_key(kb, OP_INSERT);
        end
        kb = {8'hEE, 8'hEE};                queue_key(kb, OP_INSERT, 1'b1);
        kb = {8'hEE, 8'hEE};                queue_key(kb, OP_LOOKUP);
        kb = {8'hFA, 8'd7, 8'hF5};          queue_key(kb, OP_INSERT);
        kb = {8'hFA, 8'd9, 8'hF5};          queue_key(kb, OP_LOOKUP);
        for (int i = 0; i < 24; i++) queue_key(vocab[i], OP_LOOKUP);

        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
